FILE: sv/cbu_pkg.sv
// cbu_pkg: shared types, constants and helper functions for the chroma block upsampler.
// Used by every module of the block; no dependencies.
package cbu_pkg;

    localparam int BLOCK_EDGE  = 8;
    localparam int MAX_BLOCKS  = 4;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_IN_WIDE  = 2'd0,
        REG_IN_TALL  = 2'd1,
        REG_OUT_WIDE = 2'd2,
        REG_OUT_TALL = 2'd3
    } reg_index_t;

    // Replication factors and output line stride; the user must hold them fixed while the block runs (not enforced)
    typedef struct packed {
        logic [2:0] h;
        logic [2:0] v;
        logic [5:0] line;
    } scale_t;

    // One queued request: a sample and the origin of its run in the output MCU
    typedef struct packed {
        logic [7:0] value;
        logic [6:0] base_row;
        logic [6:0] base_col;
        logic       comp_end;
    } run_t;

    function automatic logic [2:0] clamp_blocks(input logic [2:0] n);
        logic [2:0] r;
        r = n;
        if (n == 3'd0)
        begin
            r = 3'd1;
        end
        else if (n > 3'(MAX_BLOCKS))
        begin
            r = 3'(MAX_BLOCKS);
        end
        return r;
    endfunction

    // Truncated quotient of two clamped block counts, by comparison against multiples
    function automatic logic [2:0] block_ratio(input logic [2:0] num, input logic [2:0] den);
        logic [4:0] q;
        q = 5'd0;
        for (int k = 1; k <= MAX_BLOCKS; k++)
        begin
            if ({2'b00, num} >= 5'(k) * {2'b00, den})
            begin
                q = 5'(k);
            end
        end
        return q[2:0];
    endfunction

endpackage

FILE: sv/cbu_front.sv
// cbu_front: accepts samples, tracks block and pixel position, computes run origin.
// Depends on cbu_pkg (scale_t, run_t, BLOCK_EDGE).
module cbu_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [7:0]        sample,
    input  cbu_pkg::scale_t   scale,
    input  logic [2:0]        iw,
    input  logic [2:0]        ih,
    output logic              enq_valid,
    output cbu_pkg::run_t     enq_data
);

    logic [1:0] block_col_reg, block_col_next;
    logic [1:0] block_row_reg, block_row_next;
    logic [2:0] pixel_col_reg, pixel_col_next;
    logic [2:0] pixel_row_reg, pixel_row_next;

    logic       accept;
    logic       last_pc, last_pr, last_bc, last_br;
    logic [4:0] row_idx, col_idx;
    logic [7:0] row_prod, col_prod;

    assign accept  = push && !full;
    assign last_pc = pixel_col_reg >= 3'(cbu_pkg::BLOCK_EDGE - 1);
    assign last_pr = pixel_row_reg >= 3'(cbu_pkg::BLOCK_EDGE - 1);
    assign last_bc = ({1'b0, block_col_reg} + 3'd1) >= iw;
    assign last_br = ({1'b0, block_row_reg} + 3'd1) >= ih;

    // block * 8 + pixel
    assign row_idx  = {block_row_reg, pixel_row_reg};
    assign col_idx  = {block_col_reg, pixel_col_reg};
    assign row_prod = {3'b000, row_idx} * {5'b00000, scale.v};
    assign col_prod = {3'b000, col_idx} * {5'b00000, scale.h};

    assign enq_valid         = accept && (scale.h != 3'd0) && (scale.v != 3'd0);
    assign enq_data.value    = sample;
    assign enq_data.base_row = row_prod[6:0];
    assign enq_data.base_col = col_prod[6:0];
    assign enq_data.comp_end = last_pc && last_pr && last_bc && last_br;

    always_comb
    begin
        block_col_next = block_col_reg;
        block_row_next = block_row_reg;
        pixel_col_next = pixel_col_reg;
        pixel_row_next = pixel_row_reg;
        if (accept)
        begin
            if (last_pc)
            begin
                pixel_col_next = 3'd0;
                if (last_pr)
                begin
                    pixel_row_next = 3'd0;
                    if (last_bc)
                    begin
                        block_col_next = 2'd0;
                        block_row_next = last_br ? 2'd0 : block_row_reg + 2'd1;
                    end
                    else
                    begin
                        block_col_next = block_col_reg + 2'd1;
                    end
                end
                else
                begin
                    pixel_row_next = pixel_row_reg + 3'd1;
                end
            end
            else
            begin
                pixel_col_next = pixel_col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_col_reg <= 2'd0;
            block_row_reg <= 2'd0;
            pixel_col_reg <= 3'd0;
            pixel_row_reg <= 3'd0;
        end
        else
        begin
            block_col_reg <= block_col_next;
            block_row_reg <= block_row_next;
            pixel_col_reg <= pixel_col_next;
            pixel_row_reg <= pixel_row_next;
        end
    end

endmodule

FILE: sv/cbu_queue.sv
// cbu_queue: short request queue between the front and back ends.
// Depends on cbu_pkg (run_t, QUEUE_DEPTH).
module cbu_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  cbu_pkg::run_t     wr_data,
    input  logic              rd_en,
    output logic              rd_valid,
    output cbu_pkg::run_t     rd_data,
    output logic              full
);

    localparam int PtrW = (cbu_pkg::QUEUE_DEPTH > 1) ? $clog2(cbu_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(cbu_pkg::QUEUE_DEPTH + 1);

    cbu_pkg::run_t entry_reg [cbu_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_wr, do_rd;

    assign rd_valid = count_reg != CntW'(0);
    assign full     = count_reg == CntW'(cbu_pkg::QUEUE_DEPTH);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(cbu_pkg::QUEUE_DEPTH - 1)) ? PtrW'(0)
                                                                         : wr_ptr_reg + PtrW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(cbu_pkg::QUEUE_DEPTH - 1)) ? PtrW'(0)
                                                                         : rd_ptr_reg + PtrW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= PtrW'(0);
            rd_ptr_reg <= PtrW'(0);
            count_reg  <= CntW'(0);
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(cbu_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule

FILE: sv/cbu_back.sv
// cbu_back: copy sequencer; expands each queued request into h*v addressed copies.
// Depends on cbu_pkg (scale_t, run_t).
module cbu_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  cbu_pkg::scale_t   scale,
    input  logic              q_valid,
    input  cbu_pkg::run_t     q_data,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        pixel,
    output logic [9:0]        out_address,
    output logic              run_last,
    output logic              component_last
);

    logic       busy_reg, busy_next;
    logic [1:0] cc_reg, cc_next;
    logic [1:0] cr_reg, cr_next;
    logic [9:0] row_addr_reg, row_addr_next;
    logic [6:0] base_col_reg, base_col_next;
    logic [7:0] value_reg, value_next;
    logic       comp_reg, comp_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] pixel_reg, pixel_next;
    logic [9:0] addr_reg, addr_next;
    logic       run_last_reg, run_last_next;
    logic       comp_last_reg, comp_last_next;

    logic        emit, load, col_end, row_end, run_end;
    logic [12:0] row_start;
    logic [9:0]  copy_addr;

    assign emit      = busy_reg && (!out_valid_reg || pop);
    assign col_end   = ({1'b0, cc_reg} + 3'd1) == scale.h;
    assign row_end   = ({1'b0, cr_reg} + 3'd1) == scale.v;
    assign run_end   = col_end && row_end;
    // next run starts in the cycle the current one issues its last copy
    assign load      = q_valid && (!busy_reg || (emit && run_end));
    assign q_pop     = load;
    assign row_start = {6'b0, q_data.base_row} * {7'b0, scale.line};
    assign copy_addr = row_addr_reg + {3'b000, base_col_reg} + {8'b0, cc_reg};

    always_comb
    begin
        busy_next     = busy_reg;
        cc_next       = cc_reg;
        cr_next       = cr_reg;
        row_addr_next = row_addr_reg;
        base_col_next = base_col_reg;
        value_next    = value_reg;
        comp_next     = comp_reg;
        if (load)
        begin
            busy_next     = 1'b1;
            cc_next       = 2'd0;
            cr_next       = 2'd0;
            row_addr_next = row_start[9:0];
            base_col_next = q_data.base_col;
            value_next    = q_data.value;
            comp_next     = q_data.comp_end;
        end
        else if (emit)
        begin
            if (run_end)
            begin
                busy_next = 1'b0;
            end
            else if (col_end)
            begin
                cc_next       = 2'd0;
                cr_next       = cr_reg + 2'd1;
                row_addr_next = row_addr_reg + {4'b0, scale.line};
            end
            else
            begin
                cc_next = cc_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pixel_next     = pixel_reg;
        addr_next      = addr_reg;
        run_last_next  = run_last_reg;
        comp_last_next = comp_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pixel_next     = value_reg;
            addr_next      = copy_addr;
            run_last_next  = run_end;
            comp_last_next = run_end && comp_reg;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cc_reg        <= 2'd0;
            cr_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cc_reg        <= cc_next;
            cr_reg        <= cr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_addr_reg  <= row_addr_next;
        base_col_reg  <= base_col_next;
        value_reg     <= value_next;
        comp_reg      <= comp_next;
        pixel_reg     <= pixel_next;
        addr_reg      <= addr_next;
        run_last_reg  <= run_last_next;
        comp_last_reg <= comp_last_next;
    end

    assign empty          = !out_valid_reg;
    assign pixel          = pixel_reg;
    assign out_address    = addr_reg;
    assign run_last       = run_last_reg;
    assign component_last = comp_last_reg;

    a_comp_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && comp_last_reg) |-> run_last_reg)
        else $error("component end flagged on a copy that does not end its run");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && cc_reg == 2'd0 && cr_reg == 2'd0))
        else $error("new run did not start at its first copy");

    a_cursor_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (({1'b0, cc_reg} < scale.h) && ({1'b0, cr_reg} < scale.v)))
        else $error("copy cursor outside the run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !run_end) |=> busy_reg)
        else $error("run dropped before its last copy");

endmodule

FILE: sv/chroma_block_upsampler.sv
// chroma_block_upsampler: top level; configuration registers, front end, queue, back end.
// Depends on cbu_pkg, cbu_front, cbu_queue, cbu_back.
//
//  channel   side   handshake              payload
//  input     in     push / full            sample
//  result    out    pop / empty            pixel, out_address, run_last, component_last
//  config    in     psel/penable/pwrite    paddr, pwdata -> prdata (pready tied high)
//
// Each sample expands into h*v copies at the back end; while results are popped, the copy
// sequencer issues one copy per cycle and single-copy samples go at one per cycle.
// When idle, a taken sample goes through the queue and the sequencer to the output register.
// Reset clears position counters and queue; registers come up at 1 (h = v = 1, stride 8).
// A held result (pop low) stalls the sequencer; full rises once the two-entry queue fills.
module chroma_block_upsampler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  sample,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  pixel,
    output logic [9:0]  out_address,
    output logic        run_last,
    output logic        component_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] in_wide_reg, in_tall_reg, out_wide_reg, out_tall_reg;
    logic       cfg_wr;
    logic [2:0] iw, ih, ow, oh;
    cbu_pkg::reg_index_t reg_sel;
    cbu_pkg::scale_t     scale;

    logic          enq_valid, q_valid, q_pop;
    cbu_pkg::run_t enq_data, q_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = cbu_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_wide_reg  <= 3'd1;
            in_tall_reg  <= 3'd1;
            out_wide_reg <= 3'd1;
            out_tall_reg <= 3'd1;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                cbu_pkg::REG_IN_WIDE:  in_wide_reg  <= pwdata[2:0];
                cbu_pkg::REG_IN_TALL:  in_tall_reg  <= pwdata[2:0];
                cbu_pkg::REG_OUT_WIDE: out_wide_reg <= pwdata[2:0];
                cbu_pkg::REG_OUT_TALL: out_tall_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            cbu_pkg::REG_IN_WIDE:  prdata = {29'b0, in_wide_reg};
            cbu_pkg::REG_IN_TALL:  prdata = {29'b0, in_tall_reg};
            cbu_pkg::REG_OUT_WIDE: prdata = {29'b0, out_wide_reg};
            cbu_pkg::REG_OUT_TALL: prdata = {29'b0, out_tall_reg};
            default:               prdata = 32'b0;
        endcase
    end

    assign iw = cbu_pkg::clamp_blocks(in_wide_reg);
    assign ih = cbu_pkg::clamp_blocks(in_tall_reg);
    assign ow = cbu_pkg::clamp_blocks(out_wide_reg);
    assign oh = cbu_pkg::clamp_blocks(out_tall_reg);

    assign scale.h    = cbu_pkg::block_ratio(ow, iw);
    assign scale.v    = cbu_pkg::block_ratio(oh, ih);
    assign scale.line = {ow, 3'b000};   // BLOCK_EDGE * ow

    cbu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .scale     (scale),
        .iw        (iw),
        .ih        (ih),
        .enq_valid (enq_valid),
        .enq_data  (enq_data)
    );

    cbu_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (enq_valid),
        .wr_data  (enq_data),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data),
        .full     (full)
    );

    cbu_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .scale          (scale),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .pixel          (pixel),
        .out_address    (out_address),
        .run_last       (run_last),
        .component_last (component_last)
    );

endmodule
